### rtl/tcw_pkg.sv
package tcw_pkg;

    localparam int COLS_DEF = 80;
    localparam int ROWS_DEF = 25;

    localparam int CELL_W   = 16;
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int COORD_W  = 8;
    localparam int FUNC_W   = 2;
    localparam int CURSOR_W = 11;
    localparam int CFG_IDX_W = 1;

    localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_BACK  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_ATTR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_ATTR   = 1'd1;

    localparam logic [ATTR_W-1:0] DEFAULT_ATTR_RST = 8'd15;
    localparam logic [ATTR_W-1:0] ERROR_ATTR_RST   = 8'd244;

    localparam logic [CHAR_W-1:0] NL_CODE    = 8'd10;
    localparam logic [CHAR_W-1:0] SPACE_CODE = 8'd32;
    localparam logic [CHAR_W-1:0] MARK_CODE  = 8'd88;

    typedef enum logic [6:0] {
        ST_INIT   = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_EXEC   = 7'b0000100,
        ST_READ   = 7'b0001000,
        ST_SCROLL = 7'b0010000,
        ST_FILL   = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

endpackage

### rtl/text_console_writer_top.sv
// Text console writer: a screen store of COLS*ROWS 16-bit cells (character in the low byte,
// attribute in the high byte) held in one synchronous RAM, plus a cursor kept as cell index,
// row and column. One item is taken at a time and gives exactly one result. A put, an
// out-of-range put or a backspace is done in ST_EXEC; a read goes on through ST_READ.
// A put that runs off the end of the screen scrolls: the RAM is swept once with one read and
// one write per cycle and the last row is then zeroed. Clear writes one cell per cycle.
// The single RAM write port sets this pace. After reset the RAM is zeroed in a pass over
// all COLS*ROWS cells during which in_ready stays low; configuration writes are taken at
// any time.
module text_console_writer_top
    import tcw_pkg::*;
#(
    parameter int COLS = COLS_DEF,
    parameter int ROWS = ROWS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [ATTR_W-1:0]    cfg_wdata,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [FUNC_W-1:0]    func,
    input  logic [CHAR_W-1:0]    char_code,
    input  logic                 use_cursor,
    input  logic [COORD_W-1:0]   column,
    input  logic [COORD_W-1:0]   row_index,
    input  logic [ATTR_W-1:0]    attr,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [CURSOR_W-1:0]  cursor_cell,
    output logic [CHAR_W-1:0]    cell_char,
    output logic [ATTR_W-1:0]    cell_attr,
    output logic                 out_of_range,
    output logic                 scrolled
);

    localparam int CELLS = COLS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int LW    = 2 * COORD_W;

    localparam logic [AW-1:0]      LAST_CELL  = AW'(CELLS - 1);
    localparam logic [AW-1:0]      COPY_CNT   = AW'(CELLS - COLS);
    localparam logic [AW-1:0]      COLS_A     = AW'(COLS);
    localparam logic [COORD_W-1:0] LAST_COL   = COORD_W'(COLS - 1);
    localparam logic [COORD_W-1:0] LAST_ROW   = COORD_W'(ROWS - 1);
    localparam logic [COORD_W-1:0] COLS_C     = COORD_W'(COLS);
    localparam logic [COORD_W-1:0] ROWS_C     = COORD_W'(ROWS);
    localparam logic [COORD_W:0]   ROWS_X     = (COORD_W + 1)'(ROWS);
    localparam logic [LW-1:0]      COLS_L     = LW'(COLS);

    state_t state_reg, state_next;

    logic [AW-1:0]     sweep_reg, sweep_next;
    logic [CELL_W-1:0] fill_reg, fill_next;

    logic [AW-1:0]      cur_idx_reg, cur_idx_next;
    logic [COORD_W-1:0] cur_row_reg, cur_row_next;
    logic [COORD_W-1:0] cur_col_reg, cur_col_next;

    logic [ATTR_W-1:0] def_attr_reg, err_attr_reg;

    // latched item
    logic [FUNC_W-1:0]  func_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic [ATTR_W-1:0]  attr_reg;
    logic               oor_reg;
    logic [AW-1:0]      pos_reg;
    logic [COORD_W-1:0] trow_reg;
    logic [COORD_W-1:0] tcol_reg;

    // pending result
    logic              res_oor_reg, res_oor_next;
    logic              res_scr_reg, res_scr_next;
    logic [CHAR_W-1:0] res_char_reg, res_char_next;
    logic [ATTR_W-1:0] res_attr_reg, res_attr_next;

    logic                out_valid_reg, out_valid_next;
    logic [CURSOR_W-1:0] out_cursor_reg;
    logic [CHAR_W-1:0]   out_char_reg;
    logic [ATTR_W-1:0]   out_attr_reg;
    logic                out_oor_reg;
    logic                out_scr_reg;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    logic accept;
    logic finish;
    logic out_load;

    logic [LW-1:0] lin_idx;
    logic          in_oor;

    logic               is_nl;
    logic               step_row;
    logic [COORD_W:0]   put_row;
    logic [COORD_W-1:0] put_col;
    logic [AW:0]        put_idx;
    logic               do_scroll;

    logic [AW-1:0]      bs_idx;
    logic [COORD_W-1:0] bs_row;
    logic [COORD_W-1:0] bs_col;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    assign lin_idx = LW'(row_index) * COLS_L + LW'(column);
    assign in_oor  = !use_cursor && ((column >= COLS_C) || (row_index >= ROWS_C));

    // cursor step for a put
    assign is_nl     = (char_reg == NL_CODE);
    assign step_row  = is_nl || (tcol_reg == LAST_COL);
    assign put_row   = step_row ? ({1'b0, trow_reg} + 1'b1) : {1'b0, trow_reg};
    assign put_col   = step_row ? '0 : tcol_reg + 1'b1;
    assign put_idx   = is_nl ? ((AW + 1)'(pos_reg) - (AW + 1)'(tcol_reg) + (AW + 1)'(COLS))
                             : ((AW + 1)'(pos_reg) + 1'b1);
    assign do_scroll = (put_row == ROWS_X);

    // cursor step for a backspace, pinned at cell 0
    always_comb
    begin
        bs_idx = cur_idx_reg;
        bs_row = cur_row_reg;
        bs_col = cur_col_reg;
        if (cur_idx_reg != '0)
        begin
            bs_idx = cur_idx_reg - 1'b1;
            if (cur_col_reg == '0)
            begin
                bs_row = cur_row_reg - 1'b1;
                bs_col = LAST_COL;
            end
            else
            begin
                bs_col = cur_col_reg - 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        sweep_next    = sweep_reg;
        fill_next     = fill_reg;
        cur_idx_next  = cur_idx_reg;
        cur_row_next  = cur_row_reg;
        cur_col_next  = cur_col_reg;
        res_oor_next  = res_oor_reg;
        res_scr_next  = res_scr_reg;
        res_char_next = res_char_reg;
        res_attr_next = res_attr_reg;
        ram_we        = 1'b0;
        ram_waddr     = sweep_reg;
        ram_wdata     = fill_reg;
        ram_re        = 1'b0;
        ram_raddr     = pos_reg;
        finish        = 1'b0;

        case (state_reg)
            ST_INIT:
            begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                if (sweep_reg == LAST_CELL)
                begin
                    sweep_next = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                res_oor_next  = 1'b0;
                res_scr_next  = 1'b0;
                res_char_next = '0;
                res_attr_next = '0;
                case (func_reg)
                    FUNC_PUT:
                    begin
                        res_oor_next = oor_reg;
                        if (oor_reg)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = LAST_CELL;
                            ram_wdata = {err_attr_reg, MARK_CODE};
                            finish    = 1'b1;
                        end
                        else
                        begin
                            ram_we    = !is_nl;
                            ram_waddr = pos_reg;
                            ram_wdata = {attr_reg, char_reg};
                            if (do_scroll)
                            begin
                                cur_idx_next = COPY_CNT;
                                cur_row_next = LAST_ROW;
                                cur_col_next = '0;
                                res_scr_next = 1'b1;
                                sweep_next   = '0;
                                state_next   = ST_SCROLL;
                            end
                            else
                            begin
                                cur_idx_next = put_idx[AW-1:0];
                                cur_row_next = put_row[COORD_W-1:0];
                                cur_col_next = put_col;
                                finish       = 1'b1;
                            end
                        end
                    end
                    FUNC_CLEAR:
                    begin
                        cur_idx_next = '0;
                        cur_row_next = '0;
                        cur_col_next = '0;
                        sweep_next   = '0;
                        fill_next    = {def_attr_reg, SPACE_CODE};
                        state_next   = ST_FILL;
                    end
                    FUNC_BACK:
                    begin
                        ram_we       = 1'b1;
                        ram_waddr    = bs_idx;
                        ram_wdata    = {def_attr_reg, SPACE_CODE};
                        cur_idx_next = bs_idx;
                        cur_row_next = bs_row;
                        cur_col_next = bs_col;
                        finish       = 1'b1;
                    end
                    default:
                    begin
                        res_oor_next = oor_reg;
                        if (oor_reg)
                        begin
                            finish = 1'b1;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = pos_reg;
                            state_next = ST_READ;
                        end
                    end
                endcase
            end
            ST_READ:
            begin
                res_char_next = ram_rdata[CHAR_W-1:0];
                res_attr_next = ram_rdata[CELL_W-1:CHAR_W];
                finish        = 1'b1;
            end
            ST_SCROLL:
            begin
                // read runs one row ahead, write stores the cell read in the previous cycle
                ram_we    = (sweep_reg != '0);
                ram_waddr = sweep_reg - 1'b1;
                ram_wdata = ram_rdata;
                ram_re    = (sweep_reg < COPY_CNT);
                ram_raddr = sweep_reg + COLS_A;
                if (sweep_reg == COPY_CNT)
                begin
                    fill_next  = '0;
                    state_next = ST_FILL;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            ST_FILL:
            begin
                ram_we = 1'b1;
                if (sweep_reg == LAST_CELL)
                begin
                    finish = 1'b1;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                finish = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (finish)
        begin
            state_next = (!out_valid_reg || out_ready) ? ST_IDLE : ST_DONE;
        end
    end

    assign out_load = finish && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            sweep_reg     <= '0;
            cur_idx_reg   <= '0;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            def_attr_reg  <= DEFAULT_ATTR_RST;
            err_attr_reg  <= ERROR_ATTR_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            cur_idx_reg   <= cur_idx_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_DEFAULT_ATTR: def_attr_reg <= cfg_wdata;
                    CFG_ERROR_ATTR:   err_attr_reg <= cfg_wdata;
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fill_reg     <= fill_next;
        res_oor_reg  <= res_oor_next;
        res_scr_reg  <= res_scr_next;
        res_char_reg <= res_char_next;
        res_attr_reg <= res_attr_next;
        if (accept)
        begin
            func_reg <= func;
            char_reg <= char_code;
            attr_reg <= (attr == '0) ? def_attr_reg : attr;
            oor_reg  <= in_oor;
            if (use_cursor)
            begin
                pos_reg  <= cur_idx_reg;
                trow_reg <= cur_row_reg;
                tcol_reg <= cur_col_reg;
            end
            else
            begin
                pos_reg  <= lin_idx[AW-1:0];
                trow_reg <= row_index;
                tcol_reg <= column;
            end
        end
        if (out_load)
        begin
            out_cursor_reg <= CURSOR_W'(cur_idx_next);
            out_char_reg   <= res_char_next;
            out_attr_reg   <= res_attr_next;
            out_oor_reg    <= res_oor_next;
            out_scr_reg    <= res_scr_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign cursor_cell  = out_cursor_reg;
    assign cell_char    = out_char_reg;
    assign cell_attr    = out_attr_reg;
    assign out_of_range = out_oor_reg;
    assign scrolled     = out_scr_reg;

endmodule

### rtl/tcw_ram.sv
module tcw_ram
    import tcw_pkg::*;
#(
    parameter int WIDTH = CELL_W,
    parameter int DEPTH = COLS_DEF * ROWS_DEF
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/tcw_checker.sv
module tcw_checker
    import tcw_pkg::*;
#(
    parameter int COLS = COLS_DEF,
    parameter int ROWS = ROWS_DEF
)
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [CURSOR_W-1:0]  cursor_cell,
    input logic [CHAR_W-1:0]    cell_char,
    input logic [ATTR_W-1:0]    cell_attr,
    input logic                 out_of_range,
    input logic                 scrolled
);

    // one item in flight: no second transfer right after the first
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken twice in a row");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(cursor_cell) < COLS * ROWS))
        else $error("cursor beyond screen");

    a_oor_no_scroll: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_of_range |-> !scrolled)
        else $error("out-of-range result marked as scrolled");

    a_oor_cell_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_of_range |-> (cell_char == '0) && (cell_attr == '0))
        else $error("out-of-range result carries cell data");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cursor_cell) && $stable(cell_char)
            && $stable(cell_attr) && $stable(out_of_range) && $stable(scrolled))
        else $error("stalled result changed");

endmodule

bind text_console_writer_top tcw_checker #(
    .COLS (COLS),
    .ROWS (ROWS)
) u_tcw_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cursor_cell  (cursor_cell),
    .cell_char    (cell_char),
    .cell_attr    (cell_attr),
    .out_of_range (out_of_range),
    .scrolled     (scrolled)
);

### verif/testbench.sv
module testbench;
    import tcw_pkg::*;

    localparam int SCR_CELLS   = COLS_DEF * ROWS_DEF;
    localparam int STALL_LIMIT = 20000;
    localparam int OPS_PER_SET = 350;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [CHAR_W-1:0]  char_code;
        logic               use_cursor;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row_index;
        logic [ATTR_W-1:0]  attr;
    } console_op_t;

    typedef struct packed {
        logic [CURSOR_W-1:0] cursor_cell;
        logic [CHAR_W-1:0]   cell_char;
        logic [ATTR_W-1:0]   cell_attr;
        logic                out_of_range;
        logic                scrolled;
    } console_report_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = CFG_DEFAULT_ATTR;
    logic [ATTR_W-1:0]    cfg_wdata = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [FUNC_W-1:0]    func = FUNC_PUT;
    logic [CHAR_W-1:0]    char_code = '0;
    logic                 use_cursor = 1'b0;
    logic [COORD_W-1:0]   column = '0;
    logic [COORD_W-1:0]   row_index = '0;
    logic [ATTR_W-1:0]    attr = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [CURSOR_W-1:0]  cursor_cell;
    logic [CHAR_W-1:0]    cell_char;
    logic [ATTR_W-1:0]    cell_attr;
    logic                 out_of_range;
    logic                 scrolled;

    text_console_writer_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .char_code    (char_code),
        .use_cursor   (use_cursor),
        .column       (column),
        .row_index    (row_index),
        .attr         (attr),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .cursor_cell  (cursor_cell),
        .cell_char    (cell_char),
        .cell_attr    (cell_attr),
        .out_of_range (out_of_range),
        .scrolled     (scrolled)
    );

    always #5 clk = ~clk;

    // shadow copy of the console
    logic [CELL_W-1:0] shadow_screen [SCR_CELLS];
    int                shadow_cursor;
    logic [ATTR_W-1:0] shadow_dflt_attr;
    logic [ATTR_W-1:0] shadow_err_attr;

    console_op_t     console_ops_to_send [$];
    console_report_t console_reports_due [$];

    int ops_issued = 0;
    int reports_seen = 0;
    int mismatches = 0;
    int scroll_count = 0;
    int clear_count = 0;
    int oor_count = 0;
    int read_count = 0;
    int settings_used = 1;

    function automatic console_report_t apply_console_op(console_op_t op);
        console_report_t rep;
        int              pos;
        logic [ATTR_W-1:0] at;
        rep = '0;
        pos = 0;
        case (op.func)
            FUNC_PUT, FUNC_READ:
            begin
                if (op.use_cursor)
                    pos = shadow_cursor;
                else if (op.column >= COLS_DEF || op.row_index >= ROWS_DEF)
                    rep.out_of_range = 1'b1;
                else
                    pos = op.row_index * COLS_DEF + op.column;
                if (op.func == FUNC_PUT) begin
                    if (rep.out_of_range) begin
                        shadow_screen[SCR_CELLS-1] = {shadow_err_attr, MARK_CODE};
                    end
                    else begin
                        at = (op.attr == '0) ? shadow_dflt_attr : op.attr;
                        if (op.char_code == NL_CODE) begin
                            pos = (pos / COLS_DEF + 1) * COLS_DEF;
                        end
                        else begin
                            shadow_screen[pos] = {at, op.char_code};
                            pos = pos + 1;
                        end
                        if (pos >= SCR_CELLS) begin
                            for (int i = 0; i < SCR_CELLS - COLS_DEF; i++)
                                shadow_screen[i] = shadow_screen[i+COLS_DEF];
                            for (int i = SCR_CELLS - COLS_DEF; i < SCR_CELLS; i++)
                                shadow_screen[i] = '0;
                            pos = pos - COLS_DEF;
                            rep.scrolled = 1'b1;
                        end
                        shadow_cursor = pos;
                    end
                end
                else if (!rep.out_of_range) begin
                    rep.cell_char = shadow_screen[pos][CHAR_W-1:0];
                    rep.cell_attr = shadow_screen[pos][CELL_W-1:CHAR_W];
                end
            end
            FUNC_CLEAR:
            begin
                for (int i = 0; i < SCR_CELLS; i++)
                    shadow_screen[i] = {shadow_dflt_attr, SPACE_CODE};
                shadow_cursor = 0;
            end
            default:
            begin
                pos = (shadow_cursor == 0) ? 0 : shadow_cursor - 1;
                shadow_screen[pos] = {shadow_dflt_attr, SPACE_CODE};
                shadow_cursor = pos;
            end
        endcase
        rep.cursor_cell = shadow_cursor[CURSOR_W-1:0];
        return rep;
    endfunction

    function automatic console_op_t make_op(logic [FUNC_W-1:0] f, logic [CHAR_W-1:0] ch,
                                            logic uc, logic [COORD_W-1:0] col,
                                            logic [COORD_W-1:0] row, logic [ATTR_W-1:0] at);
        console_op_t op;
        op.func       = f;
        op.char_code  = ch;
        op.use_cursor = uc;
        op.column     = col;
        op.row_index  = row;
        op.attr       = at;
        return op;
    endfunction

    function automatic console_op_t random_console_op();
        console_op_t op;
        int          sel;
        // unused fields carry random noise
        op.func       = FUNC_PUT;
        op.char_code  = CHAR_W'($urandom);
        op.use_cursor = 1'($urandom);
        op.column     = COORD_W'($urandom);
        op.row_index  = COORD_W'($urandom);
        op.attr       = ATTR_W'($urandom);
        sel = $urandom_range(0, 99);
        if (sel < 65 || (sel >= 73 && sel < 99)) begin
            op.func = (sel < 65) ? FUNC_PUT : FUNC_READ;
            op.use_cursor = (sel < 45) || (sel >= 73 && $urandom_range(0, 9) < 4);
            if (!op.use_cursor && $urandom_range(0, 9) != 0) begin
                // mostly on screen, leaning toward the last row and column
                op.row_index = COORD_W'(($urandom_range(0, 9) < 3) ? ROWS_DEF - 1
                                        : $urandom_range(0, ROWS_DEF - 1));
                op.column = COORD_W'(($urandom_range(0, 3) == 0) ? COLS_DEF - 1
                                     : $urandom_range(0, COLS_DEF - 1));
            end
            if (op.func == FUNC_PUT) begin
                if ($urandom_range(0, 99) < 15)
                    op.char_code = NL_CODE;
                if ($urandom_range(0, 4) == 0)
                    op.attr = '0;
            end
        end
        else if (sel < 73) begin
            op.func = FUNC_BACK;
        end
        else begin
            op.func = FUNC_CLEAR;
        end
        return op;
    endfunction

    // sender: bursts of transfers separated by random gaps
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        console_op_t     op;
        console_report_t rep;
        if (!rst_n) begin
            in_valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else begin
            if (in_valid && in_ready) begin
                rep = apply_console_op(make_op(func, char_code, use_cursor, column,
                                               row_index, attr));
                console_reports_due.push_back(rep);
                scroll_count += int'(rep.scrolled);
                oor_count += int'(rep.out_of_range);
                clear_count += int'(func == FUNC_CLEAR);
                read_count += int'(func == FUNC_READ);
            end
            if (!in_valid || in_ready) begin
                if (gap_left != 0) begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (console_ops_to_send.size() != 0) begin
                    op = console_ops_to_send.pop_front();
                    ops_issued++;
                    in_valid <= 1'b1;
                    func <= op.func;
                    char_code <= op.char_code;
                    use_cursor <= op.use_cursor;
                    column <= op.column;
                    row_index <= op.row_index;
                    attr <= op.attr;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 :
                                    $urandom_range(1, ($urandom_range(0, 4) == 0) ? 30 : 4);
                    end
                    else begin
                        burst_left <= burst_left - 1;
                    end
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: ready follows a rotating pattern, reloaded with a new random one whenever pattern_age wraps
    logic [15:0] ready_pattern = 16'hffff;
    int          pattern_age = 0;

    always @(posedge clk or negedge rst_n)
    begin
        console_report_t want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end
        else begin
            if (out_valid && out_ready) begin
                reports_seen++;
                if (console_reports_due.size() == 0) begin
                    $error("result transfer with nothing expected");
                    mismatches++;
                end
                else begin
                    want = console_reports_due.pop_front();
                    if (cursor_cell !== want.cursor_cell) begin
                        $error("cursor_cell: expected %0d, got %0d", want.cursor_cell,
                               cursor_cell);
                        mismatches++;
                    end
                    if (cell_char !== want.cell_char) begin
                        $error("cell_char: expected %0d, got %0d", want.cell_char, cell_char);
                        mismatches++;
                    end
                    if (cell_attr !== want.cell_attr) begin
                        $error("cell_attr: expected %0d, got %0d", want.cell_attr, cell_attr);
                        mismatches++;
                    end
                    if (out_of_range !== want.out_of_range) begin
                        $error("out_of_range: expected %0d, got %0d", want.out_of_range,
                               out_of_range);
                        mismatches++;
                    end
                    if (scrolled !== want.scrolled) begin
                        $error("scrolled: expected %0d, got %0d", want.scrolled, scrolled);
                        mismatches++;
                    end
                end
            end
            out_ready <= ready_pattern[0];
            if (pattern_age == 63) begin
                pattern_age <= 0;
                case ($urandom_range(0, 3))
                    0: ready_pattern <= 16'hffff;
                    1: ready_pattern <= 16'($urandom);
                    2: ready_pattern <= 16'($urandom & $urandom);
                    default: ready_pattern <= 16'($urandom | $urandom);
                endcase
            end
            else begin
                pattern_age <= pattern_age + 1;
                ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
            end
        end
    end

    // watchdog on cycles without any transfer
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    task automatic wait_console_idle();
        while (console_ops_to_send.size() != 0 || reports_seen != ops_issued)
            @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic write_attr_reg(logic [CFG_IDX_W-1:0] idx, logic [ATTR_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        if (idx == CFG_DEFAULT_ATTR)
            shadow_dflt_attr = value;
        else
            shadow_err_attr = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [ATTR_W-1:0] next_dflt;
        logic [ATTR_W-1:0] next_err;
        for (int i = 0; i < SCR_CELLS; i++)
            shadow_screen[i] = '0;
        shadow_cursor = 0;
        shadow_dflt_attr = DEFAULT_ATTR_RST;
        shadow_err_attr = ERROR_ATTR_RST;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, scroll paths, out-of-range, clear, backspace at home
        console_ops_to_send.push_back(make_op(FUNC_READ, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0));
        console_ops_to_send.push_back(make_op(FUNC_PUT, 8'd65, 1'b0, 8'd0, 8'd0, 8'd0));
        console_ops_to_send.push_back(make_op(FUNC_PUT, 8'd255, 1'b0, 8'd79, 8'd23, 8'd255));
        console_ops_to_send.push_back(make_op(FUNC_PUT, NL_CODE, 1'b1, 8'd0, 8'd0, 8'd7));
        console_ops_to_send.push_back(make_op(FUNC_READ, 8'd255, 1'b1, 8'd255, 8'd255, 8'd255));
        console_ops_to_send.push_back(make_op(FUNC_READ, 8'd0, 1'b0, 8'd79, 8'd23, 8'd0));
        console_ops_to_send.push_back(make_op(FUNC_PUT, 8'd66, 1'b0, 8'd80, 8'd0, 8'd1));
        console_ops_to_send.push_back(make_op(FUNC_PUT, 8'd67, 1'b0, 8'd0, 8'd25, 8'd1));
        console_ops_to_send.push_back(make_op(FUNC_PUT, 8'd68, 1'b0, 8'd255, 8'd255, 8'd0));
        console_ops_to_send.push_back(make_op(FUNC_READ, 8'd0, 1'b0, 8'd79, 8'd24, 8'd0));
        console_ops_to_send.push_back(make_op(FUNC_READ, 8'd0, 1'b0, 8'd80, 8'd24, 8'd0));
        console_ops_to_send.push_back(make_op(FUNC_PUT, 8'd0, 1'b0, 8'd79, 8'd24, 8'd1));
        console_ops_to_send.push_back(make_op(FUNC_BACK, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0));
        console_ops_to_send.push_back(make_op(FUNC_PUT, 8'd98, 1'b1, 8'd0, 8'd0, 8'd128));
        console_ops_to_send.push_back(make_op(FUNC_READ, 8'd0, 1'b0, 8'd79, 8'd23, 8'd0));
        console_ops_to_send.push_back(make_op(FUNC_CLEAR, 8'd255, 1'b1, 8'd255, 8'd255, 8'd255));
        console_ops_to_send.push_back(make_op(FUNC_BACK, 8'd255, 1'b1, 8'd255, 8'd255, 8'd255));
        console_ops_to_send.push_back(make_op(FUNC_READ, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0));
        console_ops_to_send.push_back(make_op(FUNC_PUT, NL_CODE, 1'b0, 8'd5, 8'd24, 8'd0));
        console_ops_to_send.push_back(make_op(FUNC_PUT, NL_CODE, 1'b0, 8'd79, 8'd0, 8'd0));
        console_ops_to_send.push_back(make_op(FUNC_READ, 8'd0, 1'b0, 8'd79, 8'd24, 8'd0));
        wait_console_idle();

        for (int set_idx = 0; set_idx < 5; set_idx++) begin
            case (set_idx)
                0: begin next_dflt = 8'd0;   next_err = 8'd255; end
                1: begin next_dflt = 8'd255; next_err = 8'd0;   end
                4: begin next_dflt = DEFAULT_ATTR_RST; next_err = ERROR_ATTR_RST; end
                default: begin next_dflt = ATTR_W'($urandom_range(1, 254));
                               next_err = ATTR_W'($urandom_range(1, 254)); end
            endcase
            write_attr_reg(CFG_DEFAULT_ATTR, next_dflt);
            write_attr_reg(CFG_ERROR_ATTR, next_err);
            settings_used++;
            repeat (OPS_PER_SET) console_ops_to_send.push_back(random_console_op());
            wait_console_idle();
        end

        // let any stray result show up
        repeat (50) @(posedge clk);
        if (console_reports_due.size() != 0) begin
            $error("%0d expected results never arrived", console_reports_due.size());
            mismatches++;
        end
        $display("checked %0d console operations under %0d attribute settings", reports_seen,
                 settings_used);
        $display("scrolls %0d, clears %0d, out-of-range %0d, reads %0d, mismatches %0d",
                 scroll_count, clear_count, oor_count, read_count, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
